// ===== rtl/fcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types, constants and the exp2 root table for the fuzzy c-means core.
// ----------------------------------------------------------------------------
`default_nettype none

package fcm_pkg;

    localparam int ACC_W  = 38;                 // squared-distance accumulator
    localparam int LG_W   = 22;                 // log2 value, 6.16
    localparam int SUM_W  = 53;                 // term and term-sum width
    localparam int FEAT_W = 16;
    localparam int EXP_W  = 16;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_CAP = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [EXP_W-1:0] EXP_RESET = 16'd8192;

    typedef enum logic [0:0] {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_t;

    typedef enum logic [0:0] {
        REG_RATIO_EXPONENT = 1'b0
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_SQ,
        ST_ACC_ADD,
        ST_FINISH,
        ST_LG_LOAD,
        ST_LG_NORM,
        ST_LG_SQ,
        ST_LG_UPD,
        ST_PW_START,
        ST_PW_LI,
        ST_PW_LK,
        ST_PW_MAG,
        ST_EX_STEP,
        ST_EX_MUL,
        ST_EX_SH,
        ST_PW_ADD,
        ST_DV_INIT,
        ST_DV_STEP,
        ST_DV_DONE,
        ST_OUT_WAIT
    } state_t;

    typedef logic [31:0] exp_tab_t [0:16];

    function automatic logic [63:0] isqrt64(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int s = 0; s < 32; s++)
        begin
            if (b > v)
            begin
                b = b >> 2;
            end
        end
        for (int s = 0; s < 32; s++)
        begin
            if (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Successive square roots of 2.0 in Q.30, evaluated at elaboration.
    function automatic exp_tab_t gen_exp_tab();
        exp_tab_t    t;
        logic [63:0] prev;
        prev = 64'd1 << 31;
        t[0] = prev[31:0];
        for (int j = 1; j <= 16; j++)
        begin
            prev = isqrt64(prev << 30);
            t[j] = prev[31:0];
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = gen_exp_tab();

endpackage

`default_nettype wire

// ===== rtl/fcm_center_mem.sv =====
// ----------------------------------------------------------------------------
// fcm_center_mem
// Center feature store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcm_center_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [fcm_pkg::FEAT_W-1:0]    wdata,
    input  wire logic [AW-1:0]                 raddr,
    output logic      [fcm_pkg::FEAT_W-1:0]    rdata
);

    logic [fcm_pkg::FEAT_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/fcm_mul.sv =====
// ----------------------------------------------------------------------------
// fcm_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module fcm_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);

    always_ff @(posedge clk)
    begin
        p <= 64'(a) * 64'(b);
    end

endmodule

`default_nettype wire

// ===== rtl/fuzzy_cmeans_membership_core.sv =====
// ----------------------------------------------------------------------------
// fuzzy_cmeans_membership_core
// Fixed-point fuzzy c-means membership inference on one shared multiplier.
// ----------------------------------------------------------------------------
// Input transactions arrive on the s_ stream. tuser = 0 writes one center
// feature; tuser = 1 supplies one sample feature, and tlast marks the final
// feature of a sample. Results leave on the m_ stream, one transaction per
// cluster (tlast on the last), or a single transaction with tuser (not_ready)
// set when no center was ever loaded. ratio_exponent is written over APB.
// For each sample feature, every cluster needs a center read, a square on
// the shared multiplier and an accumulate. The last feature then runs log2
// per cluster (a normalize loop, then squaring steps), and for every cluster
// pair an exponent multiply plus up to 16 exp2 multiplies, then a 17-step
// divider per cluster. The sequencer owns the multiplier, so s_tready is low
// for the whole of that work.
// Reset clears the accumulators, the loaded flag and the sequencer, and sets
// ratio_exponent to 8192; the center store is not cleared. When the receiver
// stalls, the result is held in the output register and the sequence waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_cmeans_membership_core #(
    parameter int NUM_CLUSTERS = 8,
    parameter int FEATURE_DIM  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // cluster_index[2:0], feature_index[6:3],
                                       // feature_value[22:7], zero[23]
    input  wire logic        s_tuser,  // req_type
    input  wire logic        s_tlast,  // sample_last
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,  // out_cluster[2:0], membership[18:3],
                                       // zero[23:19]
    output logic             m_tuser,  // not_ready
    output logic             m_tlast   // run_last
);

    localparam int CW    = $clog2(NUM_CLUSTERS);
    localparam int DEPTH = NUM_CLUSTERS * FEATURE_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W = fcm_pkg::ACC_W;
    localparam int LG_W  = fcm_pkg::LG_W;
    localparam int SUM_W = fcm_pkg::SUM_W;
    localparam logic [CW-1:0] LAST_C = CW'(NUM_CLUSTERS - 1);

    // Input fields.
    logic [2:0]  in_cluster;
    logic [3:0]  in_feature;
    logic [15:0] in_value;
    assign in_cluster = s_tdata[2:0];
    assign in_feature = s_tdata[6:3];
    assign in_value   = s_tdata[22:7];

    // Configuration register.
    logic [15:0] ratio_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= fcm_pkg::EXP_RESET;
        end
        else if (cfg_wr && paddr == {fcm_pkg::REG_RATIO_EXPONENT, 2'b00})
        begin
            ratio_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr == {fcm_pkg::REG_RATIO_EXPONENT, 2'b00}) ? {16'd0, ratio_reg}
                                                                     : 32'd0;

    // Sequencer and datapath registers.
    fcm_pkg::state_t state_reg, state_next;
    logic              loaded_reg;
    logic [CW-1:0]     c_reg, i_reg, k_reg;
    logic [3:0]        fi_reg;
    logic signed [15:0] sv_reg;
    logic              last_reg;
    logic [ACC_W-1:0]  acc_reg [0:NUM_CLUSTERS-1];
    logic [ACC_W-1:0]  dn_reg;
    logic [5:0]        b_reg;
    logic [31:0]       x_reg;
    logic [15:0]       frac_reg;
    logic [3:0]        j_reg;
    logic [LG_W-1:0]   lg_mem [0:NUM_CLUSTERS-1];
    logic [LG_W-1:0]   lg_rd_reg;
    logic [LG_W-1:0]   li_reg;
    logic              neg_reg;
    logic signed [11:0] n_reg;
    logic [15:0]       f_reg;
    logic [31:0]       m_reg;
    logic [4:0]        ej_reg;
    logic [SUM_W-1:0]  term_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  r_reg;
    logic [SUM_W+15:0] dv_reg;
    logic [16:0]       q_reg;
    logic [4:0]        dj_reg;
    logic              out_valid_reg;
    logic [2:0]        out_cluster_reg;
    logic [15:0]       out_mem_reg;
    logic              out_last_reg;
    logic              out_nr_reg;

    // Shared multiplier and center store.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_rdata;
    logic [CW-1:0] lg_addr;

    fcm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    fcm_center_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic s_acc;
    logic load_ok;
    logic samp_in_range;
    assign s_acc         = s_tvalid && s_tready;
    assign load_ok       = (int'(in_cluster) < NUM_CLUSTERS) && (int'(in_feature) < FEATURE_DIM);
    assign samp_in_range = int'(in_feature) < FEATURE_DIM;
    assign mem_waddr     = AW'(int'(in_cluster) * FEATURE_DIM + int'(in_feature));
    assign mem_raddr     = AW'(int'(c_reg) * FEATURE_DIM + int'(fi_reg));

    // Combinational datapath pieces.
    logic signed [16:0] diff;
    logic [16:0]        ad;
    logic [ACC_W:0]     acc_sum;
    logic [32:0]        sq_t;
    logic [15:0]        frac_new;
    logic [31:0]        x_new;
    logic               lk_gt;
    logic [LG_W-1:0]    dmag;
    logic [25:0]        mag;
    logic [9:0]         mhi;
    logic [15:0]        mlo;
    logic [3:0]         fbit_idx;
    logic               fbit;
    logic signed [11:0] sh;
    logic [11:0]        rs;
    logic [SUM_W:0]     sum_add;
    logic               dv_ge;

    assign diff     = 17'(sv_reg) - 17'($signed(mem_rdata));
    assign ad       = diff[16] ? 17'(-diff) : 17'(diff);
    assign acc_sum  = {1'b0, acc_reg[c_reg]} + (ACC_W+1)'(mul_p[33:0]);
    assign sq_t     = mul_p[63:31];
    assign frac_new = {frac_reg[14:0], sq_t[32]};
    assign x_new    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
    assign lk_gt    = lg_rd_reg > li_reg;
    assign dmag     = lk_gt ? (lg_rd_reg - li_reg) : (li_reg - lg_rd_reg);
    assign mag      = 26'((mul_p[38:0] + 39'd4096) >> 13);
    assign mhi      = mag[25:16];
    assign mlo      = mag[15:0];
    assign fbit_idx = 4'(5'd16 - ej_reg);
    assign fbit     = f_reg[fbit_idx];
    assign sh       = n_reg + 12'sd2;
    assign rs       = 12'(-sh);
    assign sum_add  = {1'b0, sum_reg} + {1'b0, term_reg};
    assign dv_ge    = {16'd0, r_reg} >= dv_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcm_pkg::ST_IDLE:
            begin
                if (s_acc && s_tuser == fcm_pkg::REQ_SAMPLE)
                begin
                    if (samp_in_range)
                    begin
                        state_next = fcm_pkg::ST_ACC_RD;
                    end
                    else if (s_tlast)
                    begin
                        state_next = fcm_pkg::ST_FINISH;
                    end
                end
            end
            fcm_pkg::ST_ACC_RD:  state_next = fcm_pkg::ST_ACC_SQ;
            fcm_pkg::ST_ACC_SQ:  state_next = fcm_pkg::ST_ACC_ADD;
            fcm_pkg::ST_ACC_ADD:
            begin
                if (c_reg != LAST_C)
                begin
                    state_next = fcm_pkg::ST_ACC_RD;
                end
                else
                begin
                    state_next = last_reg ? fcm_pkg::ST_FINISH : fcm_pkg::ST_IDLE;
                end
            end
            fcm_pkg::ST_FINISH:
            begin
                state_next = loaded_reg ? fcm_pkg::ST_LG_LOAD : fcm_pkg::ST_OUT_WAIT;
            end
            fcm_pkg::ST_LG_LOAD: state_next = fcm_pkg::ST_LG_NORM;
            fcm_pkg::ST_LG_NORM:
            begin
                if (dn_reg[ACC_W-1])
                begin
                    state_next = fcm_pkg::ST_LG_SQ;
                end
            end
            fcm_pkg::ST_LG_SQ:   state_next = fcm_pkg::ST_LG_UPD;
            fcm_pkg::ST_LG_UPD:
            begin
                if (j_reg != 4'd15)
                begin
                    state_next = fcm_pkg::ST_LG_SQ;
                end
                else
                begin
                    state_next = (c_reg == LAST_C) ? fcm_pkg::ST_PW_START
                                                   : fcm_pkg::ST_LG_LOAD;
                end
            end
            fcm_pkg::ST_PW_START: state_next = fcm_pkg::ST_PW_LI;
            fcm_pkg::ST_PW_LI:    state_next = fcm_pkg::ST_PW_LK;
            fcm_pkg::ST_PW_LK:    state_next = fcm_pkg::ST_PW_MAG;
            fcm_pkg::ST_PW_MAG:
            begin
                state_next = (!neg_reg && mhi >= 10'd20) ? fcm_pkg::ST_PW_ADD
                                                          : fcm_pkg::ST_EX_STEP;
            end
            fcm_pkg::ST_EX_STEP:
            begin
                if (ej_reg > 5'd16)
                begin
                    state_next = fcm_pkg::ST_EX_SH;
                end
                else if (fbit)
                begin
                    state_next = fcm_pkg::ST_EX_MUL;
                end
            end
            fcm_pkg::ST_EX_MUL: state_next = fcm_pkg::ST_EX_STEP;
            fcm_pkg::ST_EX_SH:  state_next = fcm_pkg::ST_PW_ADD;
            fcm_pkg::ST_PW_ADD:
            begin
                state_next = (k_reg == LAST_C) ? fcm_pkg::ST_DV_INIT : fcm_pkg::ST_PW_LK;
            end
            fcm_pkg::ST_DV_INIT: state_next = fcm_pkg::ST_DV_STEP;
            fcm_pkg::ST_DV_STEP:
            begin
                if (dj_reg == 5'd0)
                begin
                    state_next = fcm_pkg::ST_DV_DONE;
                end
            end
            fcm_pkg::ST_DV_DONE: state_next = fcm_pkg::ST_OUT_WAIT;
            fcm_pkg::ST_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    state_next = (out_nr_reg || out_last_reg) ? fcm_pkg::ST_IDLE
                                                              : fcm_pkg::ST_PW_START;
                end
            end
            default: state_next = fcm_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshake, multiplier operands, memory and table ports.
    always_comb
    begin
        s_tready = (state_reg == fcm_pkg::ST_IDLE);
        mem_we   = (state_reg == fcm_pkg::ST_IDLE) && s_tvalid
                   && s_tuser == fcm_pkg::REQ_LOAD && load_ok;
        mul_a    = 32'd0;
        mul_b    = 32'd0;
        lg_addr  = k_reg;
        case (state_reg)
            fcm_pkg::ST_ACC_SQ:
            begin
                mul_a = 32'(ad);
                mul_b = 32'(ad);
            end
            fcm_pkg::ST_LG_SQ:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            fcm_pkg::ST_PW_LK:
            begin
                mul_a = 32'(dmag);
                mul_b = 32'(ratio_reg);
            end
            fcm_pkg::ST_EX_STEP:
            begin
                mul_a = m_reg;
                mul_b = fcm_pkg::EXP_TAB[ej_reg];
            end
            fcm_pkg::ST_PW_START:
            begin
                lg_addr = i_reg;
            end
            fcm_pkg::ST_PW_ADD:
            begin
                lg_addr = (k_reg == LAST_C) ? '0 : k_reg + 1'b1;
            end
            default:
            begin
                lg_addr = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lg_rd_reg <= lg_mem[lg_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcm_pkg::ST_IDLE;
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            c_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            ej_reg        <= '0;
            dj_reg        <= '0;
            for (int n = 0; n < NUM_CLUSTERS; n++)
            begin
                acc_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                fcm_pkg::ST_IDLE:
                begin
                    c_reg <= '0;
                    if (mem_we)
                    begin
                        loaded_reg <= 1'b1;
                    end
                end
                fcm_pkg::ST_ACC_ADD:
                begin
                    acc_reg[c_reg] <= acc_sum[ACC_W] ? fcm_pkg::ACC_MAX
                                    : (acc_sum[ACC_W-1:0] > fcm_pkg::ACC_MAX
                                       ? fcm_pkg::ACC_MAX : acc_sum[ACC_W-1:0]);
                    c_reg <= (c_reg == LAST_C) ? '0 : c_reg + 1'b1;
                end
                fcm_pkg::ST_FINISH:
                begin
                    c_reg         <= '0;
                    out_valid_reg <= !loaded_reg;
                end
                fcm_pkg::ST_LG_LOAD:
                begin
                    j_reg <= '0;
                end
                fcm_pkg::ST_LG_UPD:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == 4'd15)
                    begin
                        c_reg <= (c_reg == LAST_C) ? '0 : c_reg + 1'b1;
                        i_reg <= '0;
                    end
                end
                fcm_pkg::ST_PW_START:
                begin
                    k_reg <= '0;
                end
                fcm_pkg::ST_PW_MAG:
                begin
                    ej_reg <= 5'd1;
                end
                fcm_pkg::ST_EX_STEP:
                begin
                    if (ej_reg <= 5'd16 && !fbit)
                    begin
                        ej_reg <= ej_reg + 1'b1;
                    end
                end
                fcm_pkg::ST_EX_MUL:
                begin
                    ej_reg <= ej_reg + 1'b1;
                end
                fcm_pkg::ST_PW_ADD:
                begin
                    k_reg <= (k_reg == LAST_C) ? '0 : k_reg + 1'b1;
                end
                fcm_pkg::ST_DV_INIT:
                begin
                    dj_reg <= 5'd16;
                end
                fcm_pkg::ST_DV_STEP:
                begin
                    dj_reg <= dj_reg - 1'b1;
                end
                fcm_pkg::ST_DV_DONE:
                begin
                    out_valid_reg <= 1'b1;
                end
                fcm_pkg::ST_OUT_WAIT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_nr_reg || out_last_reg)
                        begin
                            for (int n = 0; n < NUM_CLUSTERS; n++)
                            begin
                                acc_reg[n] <= '0;
                            end
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    c_reg <= c_reg;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fcm_pkg::ST_IDLE:
            begin
                sv_reg   <= $signed(in_value);
                fi_reg   <= in_feature;
                last_reg <= s_tlast;
            end
            fcm_pkg::ST_FINISH:
            begin
                out_cluster_reg <= 3'd0;
                out_mem_reg     <= 16'd0;
                out_last_reg    <= 1'b1;
                out_nr_reg      <= 1'b1;
            end
            fcm_pkg::ST_LG_LOAD:
            begin
                // A zero distance is clamped to one LSB.
                dn_reg   <= (acc_reg[c_reg] == '0) ? ACC_W'(1) : acc_reg[c_reg];
                b_reg    <= 6'(ACC_W - 1);
                frac_reg <= '0;
            end
            fcm_pkg::ST_LG_NORM:
            begin
                if (!dn_reg[ACC_W-1])
                begin
                    dn_reg <= dn_reg << 1;
                    b_reg  <= b_reg - 1'b1;
                end
                else
                begin
                    x_reg <= dn_reg[ACC_W-1:ACC_W-32];
                end
            end
            fcm_pkg::ST_LG_UPD:
            begin
                frac_reg <= frac_new;
                x_reg    <= x_new;
                if (j_reg == 4'd15)
                begin
                    lg_mem[c_reg] <= {b_reg, frac_new};
                end
            end
            fcm_pkg::ST_PW_START:
            begin
                sum_reg <= '0;
            end
            fcm_pkg::ST_PW_LI:
            begin
                li_reg <= lg_rd_reg;
            end
            fcm_pkg::ST_PW_LK:
            begin
                neg_reg <= lk_gt;
            end
            fcm_pkg::ST_PW_MAG:
            begin
                m_reg    <= 32'd1 << 30;
                term_reg <= fcm_pkg::SUM_CAP;
                if (!neg_reg)
                begin
                    n_reg <= $signed({2'b00, mhi});
                    f_reg <= mlo;
                end
                else if (mlo == 16'd0)
                begin
                    n_reg <= -$signed({2'b00, mhi});
                    f_reg <= 16'd0;
                end
                else
                begin
                    n_reg <= -$signed({2'b00, mhi} + 12'd1);
                    f_reg <= 16'(17'h10000 - {1'b0, mlo});
                end
            end
            fcm_pkg::ST_EX_MUL:
            begin
                m_reg <= mul_p[61:30];
            end
            fcm_pkg::ST_EX_SH:
            begin
                if (!sh[11])
                begin
                    term_reg <= SUM_W'(m_reg) << sh[4:0];
                end
                else if (rs >= 12'd32)
                begin
                    term_reg <= '0;
                end
                else
                begin
                    term_reg <= SUM_W'(m_reg >> rs[4:0]);
                end
            end
            fcm_pkg::ST_PW_ADD:
            begin
                sum_reg <= (sum_add > {1'b0, fcm_pkg::SUM_CAP}) ? fcm_pkg::SUM_CAP
                                                                 : sum_add[SUM_W-1:0];
            end
            fcm_pkg::ST_DV_INIT:
            begin
                r_reg  <= (SUM_W'(1) << 48) + (sum_reg >> 1);
                dv_reg <= {sum_reg, 16'd0};
                q_reg  <= '0;
            end
            fcm_pkg::ST_DV_STEP:
            begin
                if (dv_ge)
                begin
                    r_reg <= r_reg - dv_reg[SUM_W-1:0];
                end
                q_reg  <= {q_reg[15:0], dv_ge};
                dv_reg <= dv_reg >> 1;
            end
            fcm_pkg::ST_DV_DONE:
            begin
                out_cluster_reg <= 3'(i_reg);
                out_mem_reg     <= q_reg[16] ? 16'hFFFF : q_reg[15:0];
                out_last_reg    <= (i_reg == LAST_C);
                out_nr_reg      <= 1'b0;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_mem_reg, out_cluster_reg};
    assign m_tuser  = out_nr_reg;
    assign m_tlast  = out_last_reg;

    // A result is only presented while the sequencer waits for it.
    a_out_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("result valid while input accepted");

    // A not-ready result always closes its run.
    a_nr_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("not_ready result without tlast");

    // An exp2 multiply is only consumed right after it was issued.
    a_ex_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcm_pkg::ST_EX_MUL) |-> ($past(state_reg) == fcm_pkg::ST_EX_STEP))
        else $error("exp2 product consumed without issue");

endmodule

`default_nettype wire
